// File: hdl/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// Types and constants shared by the page framebuffer draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pfb_pkg;

  // command codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PIXEL = 2'd1;
  localparam logic [1:0] OP_RECT  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [7:0] FILL_WHITE = 8'hFF;
  localparam logic [7:0] FILL_BLACK = 8'h00;
  localparam int         PAGE_ROWS  = 8;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] rect_w;
    logic [7:0] rect_h;
    logic       draw_white;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } pfb_cmd_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_data;
  } pfb_res_t;

endpackage

`default_nettype wire

// File: hdl/pfb_ram.sv
// ----------------------------------------------------------------------------
// pfb_ram
// Generic single-clock RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hdl/page_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine
// Page-organised monochrome frame store with clear, pixel, rectangle fill
// and byte read commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; its single result
// appears on result with done high for one cycle, and the receiver cannot
// stall it. All work goes through the one frame memory; the clear sweep
// writes one byte per cycle, and a read-modify-write reads a byte in
// S_RMW_RD and writes it back in S_RMW_WR. The store holds P pages
// (SCREEN_HEIGHT/8 rounded up) of W columns. An off-screen pixel or an
// empty rectangle finishes without going busy. After reset the memory is
// swept to zero, with busy high; configuration writes are taken at any time.
`default_nettype none

module page_framebuffer_draw_engine #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  pfb_pkg::pfb_cmd_t cmd,
  output logic              done,
  output pfb_pkg::pfb_res_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  import pfb_pkg::*;

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int PG_W        = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
  localparam logic [PG_W-1:0]   LAST_PAGE = PG_W'(PAGE_COUNT - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SWEEP,
    S_READ_RD,
    S_READ_DATA,
    S_RMW_RD,
    S_RMW_WR,
    S_RECT_COL
  } state_t;

  state_t            state;
  pfb_cmd_t          cmd_r;
  logic              clear_white;
  logic [7:0]        fill;
  logic [ADDR_W-1:0] sweep_addr;
  logic [7:0]        cur_x;
  logic [PG_W-1:0]   cur_pg;
  logic [7:0]        col_i;

  logic [ADDR_W-1:0] addr;
  logic [7:0]        rect_mask;
  logic [7:0]        mask;
  logic              col_on;
  logic              col_last;
  logic              pixel_ok;
  logic              read_ok;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  assign addr = ADDR_W'(cur_x) + ADDR_W'(cur_pg) * ADDR_W'(SCREEN_WIDTH);

  // rows of the current page that fall inside the wrapped rectangle
  always_comb begin
    logic [PG_W+2:0] row;
    logic [7:0]      row8;
    rect_mask = '0;
    for (int n = 0; n < PAGE_ROWS; n++) begin
      row  = {cur_pg, 3'(n)};
      row8 = 8'(row);
      rect_mask[n] = (32'(row) < SCREEN_HEIGHT) &&
                     (8'(row8 - cmd_r.pos_y) < cmd_r.rect_h);
    end
  end

  assign mask = (cmd_r.operation == OP_PIXEL) ? (8'b1 << cmd_r.pos_y[2:0]) : rect_mask;

  assign col_on   = (32'(cur_x) < SCREEN_WIDTH);
  assign col_last = (8'(col_i + 8'd1) == cmd_r.rect_w);
  assign pixel_ok = (32'(cmd.pos_x) < SCREEN_WIDTH) && (32'(cmd.pos_y) < SCREEN_HEIGHT);
  assign read_ok  = (32'(cmd.read_page) < PAGE_COUNT) &&
                    (32'(cmd.read_column) < SCREEN_WIDTH);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr;
    ram_wdata = cmd_r.draw_white ? (ram_rdata | mask) : (ram_rdata & ~mask);
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = FILL_BLACK;
      end
      S_SWEEP: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_addr;
        ram_wdata = fill;
      end
      S_RMW_WR: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  pfb_ram #(
    .WIDTH(8),
    .DEPTH(STORE_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep_addr  <= '0;
      clear_white <= 1'b1;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        clear_white <= cfg_data;
      end
      case (state)
        S_INIT: begin
          sweep_addr <= ADDR_W'(sweep_addr + 1'b1);
          if (sweep_addr == LAST_ADDR) begin
            sweep_addr <= '0;
            state      <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            case (cmd.operation)
              OP_CLEAR: begin
                fill       <= clear_white ? FILL_WHITE : FILL_BLACK;
                sweep_addr <= '0;
                state      <= S_SWEEP;
              end
              OP_PIXEL: begin
                if (pixel_ok) begin
                  cur_x  <= cmd.pos_x;
                  cur_pg <= PG_W'(cmd.pos_y[7:3]);
                  state  <= S_RMW_RD;
                end else begin
                  done             <= 1'b1;
                  result.status    <= 1'b1;
                  result.read_data <= 8'h00;
                end
              end
              OP_RECT: begin
                if ((cmd.rect_w == 8'd0) || (cmd.rect_h == 8'd0)) begin
                  done             <= 1'b1;
                  result.status    <= 1'b0;
                  result.read_data <= 8'h00;
                end else begin
                  cur_x  <= cmd.pos_x;
                  cur_pg <= '0;
                  col_i  <= 8'd0;
                  state  <= S_RECT_COL;
                end
              end
              default: begin
                if (read_ok) begin
                  cur_x  <= {1'b0, cmd.read_column};
                  cur_pg <= PG_W'(cmd.read_page);
                  state  <= S_READ_RD;
                end else begin
                  done             <= 1'b1;
                  result.status    <= 1'b0;
                  result.read_data <= 8'h00;
                end
              end
            endcase
          end
        end
        S_SWEEP: begin
          sweep_addr <= ADDR_W'(sweep_addr + 1'b1);
          if (sweep_addr == LAST_ADDR) begin
            done             <= 1'b1;
            result.status    <= 1'b0;
            result.read_data <= 8'h00;
            state            <= S_IDLE;
          end
        end
        S_READ_RD: begin
          state <= S_READ_DATA;
        end
        S_READ_DATA: begin
          done             <= 1'b1;
          result.status    <= 1'b0;
          result.read_data <= ram_rdata;
          state            <= S_IDLE;
        end
        S_RMW_RD: begin
          state <= S_RMW_WR;
        end
        S_RMW_WR: begin
          if (cmd_r.operation == OP_PIXEL) begin
            done             <= 1'b1;
            result.status    <= 1'b0;
            result.read_data <= 8'h00;
            state            <= S_IDLE;
          end else if (cur_pg != LAST_PAGE) begin
            cur_pg <= PG_W'(cur_pg + 1'b1);
            state  <= S_RMW_RD;
          end else if (col_last) begin
            done             <= 1'b1;
            result.status    <= 1'b0;
            result.read_data <= 8'h00;
            state            <= S_IDLE;
          end else begin
            col_i  <= 8'(col_i + 8'd1);
            cur_x  <= 8'(cur_x + 8'd1);
            cur_pg <= '0;
            state  <= S_RECT_COL;
          end
        end
        S_RECT_COL: begin
          if (col_on) begin
            state <= S_RMW_RD;
          end else if (col_last) begin
            done             <= 1'b1;
            result.status    <= 1'b0;
            result.read_data <= 8'h00;
            state            <= S_IDLE;
          end else begin
            col_i <= 8'(col_i + 8'd1);
            cur_x <= 8'(cur_x + 8'd1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/pfb_checker.sv
// ----------------------------------------------------------------------------
// pfb_checker
// Port-level assertions for the page framebuffer draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pfb_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input pfb_pkg::pfb_res_t result
);

  // memory sweep after reset keeps the engine busy
  a_init_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> busy)
    else $error("engine not busy after reset");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result during reset");

  // an accepted item either finishes at once or holds the engine busy
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (done || busy))
    else $error("accepted item dropped");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    (done && result.status) |-> (result.read_data == 8'h00))
    else $error("error result carries data");

endmodule

bind page_framebuffer_draw_engine pfb_checker u_pfb_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .result(result)
);

`default_nettype wire
